// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/cnp_pkg.sv
// Package for the chord notation parser: parser phases, event and error codes,
// character constants, token and result types. No dependencies.
`timescale 1ns / 1ps

package cnp_pkg;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_GAP    = 3'd1,
    PH_CHORD  = 3'd2,
    PH_SHARP  = 3'd3,
    PH_LETTER = 3'd4,
    PH_HALT   = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_NOTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_LETTER    = 3'd1;
  localparam logic [2:0] ERR_ORDER     = 3'd2;
  localparam logic [2:0] ERR_OVERFULL  = 3'd3;
  localparam logic [2:0] ERR_CHORDS    = 3'd4;

  localparam logic [5:0] NO_TONIC  = 6'd42;
  localparam logic [5:0] OCTAVE    = 6'd14;
  localparam logic [3:0] BIG_LIMIT = 4'd5;

  localparam logic [7:0] CH_LBR   = 8'h5B;  // [
  localparam logic [7:0] CH_RBR   = 8'h5D;  // ]
  localparam logic [7:0] CH_CARET = 8'h5E;  // ^
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ,
  localparam logic [7:0] CH_BAR   = 8'h7C;  // |
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Token queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Classified text byte
  typedef struct packed {
    logic       is_lbr;
    logic       is_rbr;
    logic       is_caret;
    logic       is_comma;
    logic       is_blank;
    logic [5:0] letter;   // 0 when the byte is no note letter
  } tok_t;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] note;
    logic [6:0] chord;
    logic [3:0] cnt;
    logic [5:0] low;
    logic       big;
    logic [2:0] err;
    logic       last;
  } res_t;

  function automatic logic [5:0] letter_value(input logic [7:0] c);
    logic [5:0] v;
    case (c)
      8'h43:   v = 6'd14;  // C
      8'h44:   v = 6'd16;  // D
      8'h45:   v = 6'd18;  // E
      8'h46:   v = 6'd20;  // F
      8'h47:   v = 6'd22;  // G
      8'h41:   v = 6'd24;  // A
      8'h42:   v = 6'd26;  // B
      8'h63:   v = 6'd28;  // c
      8'h64:   v = 6'd30;  // d
      8'h65:   v = 6'd32;  // e
      8'h66:   v = 6'd34;  // f
      8'h67:   v = 6'd36;  // g
      8'h61:   v = 6'd38;  // a
      8'h62:   v = 6'd40;  // b
      default: v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/cnp_if.sv
// Valid/ready channel interfaces of the chord notation parser.
// Plain logic only; no package needed.
`timescale 1ns / 1ps

interface cnp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface cnp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [5:0] note_value;
  logic [6:0] chord_number;
  logic [3:0] notes_in_chord;
  logic [5:0] lowest_note;
  logic       big_chord;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, output event_kind, output note_value, output chord_number,
                  output notes_in_chord, output lowest_note, output big_chord,
                  output error_code, output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input note_value, input chord_number,
                  input notes_in_chord, input lowest_note, input big_chord,
                  input error_code, input last_of_run, output ready);
endinterface

// File: rtl/core/cnp_front.sv
// Front of the chord parser: classifies each text byte and queues the token.
// Depends on cnp_pkg and cnp_in_if.
`timescale 1ns / 1ps

module cnp_front (
  input  logic          clk,
  input  logic          rst_n,
  cnp_in_if.sink        in_if,
  output cnp_pkg::tok_t tok,
  output logic          tok_valid,
  input  logic          tok_pop
);
  import cnp_pkg::*;

  tok_t             q_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  tok_t             cls;
  logic             push, pop;

  // Classify the incoming byte
  always_comb begin
    cls.is_lbr   = (in_if.text_byte == CH_LBR);
    cls.is_rbr   = (in_if.text_byte == CH_RBR);
    cls.is_caret = (in_if.text_byte == CH_CARET);
    cls.is_comma = (in_if.text_byte == CH_COMMA);
    cls.is_blank = (in_if.text_byte == CH_SPACE) || (in_if.text_byte == CH_TAB) ||
                   (in_if.text_byte == CH_CR) || (in_if.text_byte == CH_LF) ||
                   (in_if.text_byte == CH_BAR);
    cls.letter   = letter_value(in_if.text_byte);
  end

  assign in_if.ready = (cnt_r != QCW'(QDEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign tok_valid   = (cnt_r != '0);
  assign pop         = tok_pop && tok_valid;
  assign tok         = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: rtl/core/cnp_back.sv
// Back of the chord parser: runs the chord grammar on queued tokens and drives
// the result channel through an output register plus one spare slot.
// Depends on cnp_pkg and cnp_out_if.
`timescale 1ns / 1ps

module cnp_back #(
  parameter int MAX_CHORD_NOTES = 8,
  parameter int MAX_CHORDS      = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cnp_pkg::tok_t tok,
  input  logic          tok_valid,
  output logic          tok_pop,
  cnp_out_if.source     out_if
);
  import cnp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [5:0] pending_r, pending_nxt;
  logic [5:0] prev_r, prev_nxt;
  logic [3:0] count_r, count_nxt;
  logic [5:0] tonic_r, tonic_nxt;
  logic [6:0] total_r, total_nxt;

  res_t       out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;
  res_t       spare_r, spare_nxt;
  logic       spare_valid_r, spare_valid_nxt;

  logic       load_ok;
  logic [1:0] nres;
  res_t       r1, r2;

  // Note ending inside a letter phase
  logic [5:0] note_v;
  logic       note_bad;
  logic [5:0] note_tonic;

  // Chord-body byte handling, shared by the chord and letter phases
  logic [3:0] cb_count;
  logic [5:0] cb_tonic;
  logic       cb_has;
  res_t       cb_res;
  phase_t     cb_phase;
  logic       cb_close;
  logic       cb_load;

  assign load_ok = !out_valid_r || out_if.ready;
  assign tok_pop = load_ok && !spare_valid_r && tok_valid;

  assign note_v     = tok.is_comma ? (pending_r - OCTAVE) : pending_r;
  assign note_bad   = (count_r != '0) && (note_v <= prev_r);
  assign note_tonic = (note_v < tonic_r) ? note_v : tonic_r;

  always_comb begin
    cb_count = (phase_r == PH_LETTER) ? count_r + 1'b1 : count_r;
    cb_tonic = (phase_r == PH_LETTER) ? note_tonic : tonic_r;
    cb_has   = 1'b0;
    cb_res   = '0;
    cb_phase = phase_r;
    cb_close = 1'b0;
    cb_load  = 1'b0;
    cb_res.chord = total_r;
    if (tok.is_rbr) begin
      cb_has       = 1'b1;
      cb_res.kind  = KIND_CLOSE;
      cb_res.cnt   = cb_count;
      cb_res.low   = cb_tonic;
      cb_res.big   = (cb_count > BIG_LIMIT);
      cb_close     = 1'b1;
      cb_phase     = PH_GAP;
    end else if (cb_count >= 4'(MAX_CHORD_NOTES)) begin
      cb_has      = 1'b1;
      cb_res.kind = KIND_ERROR;
      cb_res.err  = ERR_OVERFULL;
      cb_phase    = PH_HALT;
    end else if (tok.is_caret) begin
      cb_phase = PH_SHARP;
    end else if (tok.letter == '0) begin
      cb_has      = 1'b1;
      cb_res.kind = KIND_ERROR;
      cb_res.err  = ERR_LETTER;
      cb_phase    = PH_HALT;
    end else begin
      cb_load  = 1'b1;
      cb_phase = PH_LETTER;
    end
  end

  // Grammar step for one token: up to two results and the next parser state
  always_comb begin
    phase_nxt   = phase_r;
    pending_nxt = pending_r;
    prev_nxt    = prev_r;
    count_nxt   = count_r;
    tonic_nxt   = tonic_r;
    total_nxt   = total_r;
    nres        = 2'd0;
    r1          = '0;
    r2          = '0;
    r1.chord    = total_r;
    case (phase_r)
      PH_START, PH_GAP: begin
        if (tok.is_lbr) begin
          if (total_r >= 7'(MAX_CHORDS)) begin
            nres      = 2'd1;
            r1.kind   = KIND_ERROR;
            r1.err    = ERR_CHORDS;
            phase_nxt = PH_HALT;
          end else begin
            count_nxt = '0;
            prev_nxt  = '0;
            tonic_nxt = NO_TONIC;
            phase_nxt = PH_CHORD;
          end
        end else if (!(phase_r == PH_GAP && tok.is_blank)) begin
          nres      = 2'd1;
          r1.kind   = KIND_END;
          phase_nxt = PH_HALT;
        end
      end
      PH_CHORD: begin
        nres      = {1'b0, cb_has};
        r1        = cb_res;
        phase_nxt = cb_phase;
        if (cb_close) begin
          total_nxt = total_r + 1'b1;
        end
        if (cb_load) begin
          pending_nxt = tok.letter;
        end
      end
      PH_SHARP: begin
        if (tok.letter == '0) begin
          nres      = 2'd1;
          r1.kind   = KIND_ERROR;
          r1.err    = ERR_LETTER;
          phase_nxt = PH_HALT;
        end else begin
          pending_nxt = tok.letter + 1'b1;
          phase_nxt   = PH_LETTER;
        end
      end
      PH_LETTER: begin
        nres = 2'd1;
        r1.note = note_v;
        if (note_bad) begin
          r1.kind   = KIND_ERROR;
          r1.err    = ERR_ORDER;
          phase_nxt = PH_HALT;
        end else begin
          r1.kind   = KIND_NOTE;
          prev_nxt  = note_v;
          count_nxt = count_r + 1'b1;
          tonic_nxt = note_tonic;
          phase_nxt = PH_CHORD;
          if (!tok.is_comma) begin
            // the ending byte is also a chord-body byte: it starts the next note, closes the chord or raises an error
            nres      = cb_has ? 2'd2 : 2'd1;
            r2        = cb_res;
            phase_nxt = cb_phase;
            if (cb_close) begin
              total_nxt = total_r + 1'b1;
            end
            if (cb_load) begin
              pending_nxt = tok.letter;
            end
          end
        end
      end
      default: begin
        // halted: swallow the byte
      end
    endcase
    if (nres == 2'd1) begin
      r1.last = 1'b1;
    end
    if (nres == 2'd2) begin
      r2.last = 1'b1;
    end
  end

  // Output register and spare slot
  always_comb begin
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r;
    spare_nxt       = spare_r;
    spare_valid_nxt = spare_valid_r;
    if (load_ok) begin
      if (spare_valid_r) begin
        out_nxt         = spare_r;
        out_valid_nxt   = 1'b1;
        spare_valid_nxt = 1'b0;
      end else if (tok_valid && nres != 2'd0) begin
        out_nxt         = r1;
        out_valid_nxt   = 1'b1;
        spare_nxt       = r2;
        spare_valid_nxt = (nres == 2'd2);
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_START;
      pending_r     <= '0;
      prev_r        <= '0;
      count_r       <= '0;
      tonic_r       <= NO_TONIC;
      total_r       <= '0;
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
    end else begin
      if (tok_pop) begin
        phase_r   <= phase_nxt;
        pending_r <= pending_nxt;
        prev_r    <= prev_nxt;
        count_r   <= count_nxt;
        tonic_r   <= tonic_nxt;
        total_r   <= total_nxt;
      end
      out_valid_r   <= out_valid_nxt;
      spare_valid_r <= spare_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    spare_r <= spare_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.event_kind     = out_r.kind;
  assign out_if.note_value     = out_r.note;
  assign out_if.chord_number   = out_r.chord;
  assign out_if.notes_in_chord = out_r.cnt;
  assign out_if.lowest_note    = out_r.low;
  assign out_if.big_chord      = out_r.big;
  assign out_if.error_code     = out_r.err;
  assign out_if.last_of_run    = out_r.last;

endmodule

// File: rtl/core/chord_notation_parser_core.sv
// Top level of the chord notation parser: front classifier, token queue and
// grammar back end. Depends on cnp_pkg, cnp_if, cnp_front and cnp_back.
`timescale 1ns / 1ps
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+------------------------------------
//  in_if   | sink      | valid/ready      | text_byte[7:0]
//  out_if  | source    | valid/ready      | event_kind, note_value, chord_number,
//          |           |                  | notes_in_chord, lowest_note,
//          |           |                  | big_chord, error_code, last_of_run
//
//  Throughput: one byte per cycle while out_if.ready is high and the spare slot
//  is empty; a byte that yields two results (a note ended by ']' or by a byte
//  raising an error) holds the back end while the single output register
//  drains the spare slot. Path: a byte enters the token queue when it
//  transfers; its first result is registered in out_r when the back end pops it.
//  Reset: synchronous, active-low rst_n; parser returns to "before first chord".
//  Stalls: the two-entry token queue lets the input keep transferring while a
//  result waits on out_if.ready; in_if.ready drops only when the queue is full.

module chord_notation_parser_core #(
  parameter int MAX_CHORD_NOTES = 8,
  parameter int MAX_CHORDS      = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  cnp_in_if.sink     in_if,
  cnp_out_if.source  out_if
);
  import cnp_pkg::*;

  tok_t tok;        // classified byte at the queue head
  logic tok_valid;  // queue holds a token
  logic tok_pop;    // back end takes the head token

  // Classify bytes and buffer them ahead of the grammar
  cnp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .tok       (tok),
    .tok_valid (tok_valid),
    .tok_pop   (tok_pop)
  );

  // Advance the parser and emit note, chord, end and error events
  cnp_back #(
    .MAX_CHORD_NOTES (MAX_CHORD_NOTES),
    .MAX_CHORDS      (MAX_CHORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (tok),
    .tok_valid (tok_valid),
    .tok_pop   (tok_pop),
    .out_if    (out_if)
  );

endmodule

// File: rtl/core/cnp_checker.sv
// Port-level checks for the chord notation parser, bound to the top level.
// Depends on cnp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cnp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [5:0] out_note,
  input logic [3:0] out_cnt,
  input logic       out_big,
  input logic [2:0] out_err,
  input logic       out_last
);
  import cnp_pkg::*;

  // Hold the result while stalled
  `ASSERT_NXT(a_hold, out_valid && !out_ready,
              out_valid && $stable(out_kind) && $stable(out_note) && $stable(out_err))
  // Error code present exactly on error events
  `ASSERT_IMP(a_err_code, out_valid, (out_kind == KIND_ERROR) == (out_err != ERR_NONE))
  // Big-chord flag follows the closed chord's note count
  `ASSERT_IMP(a_big, out_valid && out_kind == KIND_CLOSE, out_big == (out_cnt > BIG_LIMIT))
  // Drop all output after the list ends or an error is transferred
  `ASSERT_NXT(a_halt, out_valid && out_ready && out_last &&
              (out_kind == KIND_END || out_kind == KIND_ERROR), !out_valid)

endmodule

bind chord_notation_parser_core cnp_checker u_cnp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_kind  (out_if.event_kind),
  .out_note  (out_if.note_value),
  .out_cnt   (out_if.notes_in_chord),
  .out_big   (out_if.big_chord),
  .out_err   (out_if.error_code),
  .out_last  (out_if.last_of_run)
);

// File: tb/tb_top.sv
// Self-checking bench for chord_notation_parser_core: streams chord text bytes
// and checks every event against an in-bench parser prediction.
// Depends on cnp_pkg, cnp_if and the parser RTL.
`timescale 1ns / 1ps

module tb_top;
  import cnp_pkg::*;

  localparam int CHORD_CAP = 8;        // notes per chord
  localparam int MAX_LIST  = 64;       // chords per list
  localparam int LIMIT     = 200000;   // cycle budget for the whole run
  localparam int SETTLE    = 20;       // quiet cycles after the last event
  localparam int LOG_CAP   = 50;       // mismatch lines printed before going quiet

  // Ways the chord list is brought to its halt; one is drawn per run
  typedef enum int {
    END_TOO_MANY, END_STRAY_BYTE, END_BAD_LETTER,
    END_CARET_CLOSE, END_DESCENT, END_OVERFULL
  } finale_t;

  logic clk = 1'b0;
  logic rst_n;

  cnp_in_if  in_ch ();
  cnp_out_if out_ch ();

  chord_notation_parser_core #(
    .MAX_CHORD_NOTES (CHORD_CAP),
    .MAX_CHORDS      (MAX_LIST)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #5 clk = ~clk;

  // Text letters in pitch order; index i is pitch 14 + 2*i
  string note_letters = "CDEFGABcdefgab";

  // Bytes waiting to be sent; bit 8 asks the sender to drain the parser first
  logic [8:0] text_q[$];
  bit         hold_next;

  // Events the parser owes us, oldest first
  res_t pending_events[$];

  // Parser state as predicted
  phase_t     cur_phase;
  logic [5:0] pending_pitch;
  logic [5:0] prior_pitch;
  logic [3:0] pitch_count;
  logic [5:0] tonic;
  logic [6:0] chords_done;

  // Events produced by the byte being predicted (at most two)
  res_t step_buf[2];
  int   step_n;

  int      errors;
  int      bytes_sent;
  int      events_seen;
  int      notes_seen;
  int      closes_seen;
  int      ends_seen;
  int      faults_seen;
  int      last_fault;
  int      cycles;
  finale_t finale;

  // --------------------------------------------------------------------------
  // Pitch helpers shared by the predictor and the text generator
  // --------------------------------------------------------------------------

  // Pitch of a plain letter, 0 when the byte is no note letter
  function automatic logic [5:0] pitch_of(input logic [7:0] c);
    for (int i = 0; i < 14; i++)
      if (c == note_letters[i]) return 6'(14 + 2 * i);
    return 6'd0;
  endfunction

  function automatic bit is_gap_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_BAR;
  endfunction

  // --------------------------------------------------------------------------
  // Parser prediction
  // --------------------------------------------------------------------------

  task automatic emit(input logic [1:0] kind, input logic [5:0] note, input logic [3:0] cnt,
                      input logic [5:0] low, input logic big, input logic [2:0] err);
    res_t r;
    r.kind  = kind;
    r.note  = note;
    r.chord = chords_done;
    r.cnt   = cnt;
    r.low   = low;
    r.big   = big;
    r.err   = err;
    r.last  = 1'b0;
    step_buf[step_n] = r;
    step_n++;
  endtask

  // Any error halts the parser for good
  task automatic abort(input logic [2:0] err, input logic [5:0] note);
    cur_phase = PH_HALT;
    emit(KIND_ERROR, note, 4'd0, 6'd0, 1'b0, err);
  endtask

  // Commit a finished note; reject it unless it rises above the previous one
  task automatic take_note(input logic [5:0] v, output bit ok);
    ok = !(pitch_count != 0 && v <= prior_pitch);
    if (!ok) begin
      abort(ERR_ORDER, v);
    end else begin
      prior_pitch = v;
      pitch_count = pitch_count + 4'd1;
      if (v < tonic) tonic = v;
      emit(KIND_NOTE, v, 4'd0, 6'd0, 1'b0, ERR_NONE);
    end
  endtask

  // Byte at the start of a note or at the chord end
  task automatic inside_chord(input logic [7:0] c);
    logic [5:0] v;
    v = pitch_of(c);
    if (c == CH_RBR) begin
      emit(KIND_CLOSE, 6'd0, pitch_count, tonic, pitch_count > BIG_LIMIT, ERR_NONE);
      chords_done = chords_done + 7'd1;
      cur_phase = PH_GAP;
    end else if (pitch_count >= CHORD_CAP) begin
      abort(ERR_OVERFULL, 6'd0);
    end else if (c == CH_CARET) begin
      cur_phase = PH_SHARP;
    end else if (v == 6'd0) begin
      abort(ERR_LETTER, 6'd0);
    end else begin
      pending_pitch = v;
      cur_phase = PH_LETTER;
    end
  endtask

  // Byte before the first chord or between chords
  task automatic between_chords(input logic [7:0] c);
    if (c == CH_LBR) begin
      if (chords_done >= MAX_LIST) begin
        abort(ERR_CHORDS, 6'd0);
      end else begin
        pitch_count = 4'd0;
        prior_pitch = 6'd0;
        tonic = NO_TONIC;
        cur_phase = PH_CHORD;
      end
    end else if (!(cur_phase == PH_GAP && is_gap_char(c))) begin
      cur_phase = PH_HALT;
      emit(KIND_END, 6'd0, 4'd0, 6'd0, 1'b0, ERR_NONE);
    end
  endtask

  // Advance the predicted parser by one transferred byte and queue its events
  task automatic predict_events(input logic [7:0] c);
    logic [5:0] v;
    bit         ok;
    step_n = 0;
    case (cur_phase)
      PH_START, PH_GAP: between_chords(c);
      PH_CHORD: inside_chord(c);
      PH_SHARP: begin
        v = pitch_of(c);
        if (v == 6'd0) begin
          abort(ERR_LETTER, 6'd0);
        end else begin
          pending_pitch = v + 6'd1;
          cur_phase = PH_LETTER;
        end
      end
      PH_LETTER: begin
        if (c == CH_COMMA) begin
          take_note(pending_pitch - OCTAVE, ok);
          if (ok) cur_phase = PH_CHORD;
        end else begin
          // the note is closed by this byte, which then starts the next step
          take_note(pending_pitch, ok);
          if (ok) begin
            cur_phase = PH_CHORD;
            inside_chord(c);
          end
        end
      end
      default: ;  // halted: every byte is swallowed silently
    endcase
    if (step_n > 0) step_buf[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++) pending_events.push_back(step_buf[i]);
  endtask

  // --------------------------------------------------------------------------
  // Text generation
  // --------------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] b);
    text_q.push_back({hold_next, b});
    hold_next = 1'b0;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Spell pitch v as text; pitches below 14 need the octave-down comma,
  // 14..27 take it now and then
  task automatic add_pitch(input int v);
    int base;
    bit low_octave;
    low_octave = (v < 14) || (v <= 27 && $urandom_range(0, 2) == 0);
    base = low_octave ? v + 14 : v;
    if (base % 2) add_byte(CH_CARET);
    add_byte(note_letters[(base - 14) / 2]);
    if (low_octave) add_byte(CH_COMMA);
  endtask

  // Spell n strictly rising pitches spread over 0..41; top is the last, -1 if none
  task automatic add_notes(input int n, output int top);
    int lo, hi, maxv, v;
    top = -1;
    for (int i = 0; i < n; i++) begin
      lo = top + 1;
      maxv = 41 - (n - 1 - i);
      hi = lo + 2 * (maxv - lo) / (n - i);
      if (hi > maxv) hi = maxv;
      v = $urandom_range(lo, hi);
      add_pitch(v);
      top = v;
    end
  endtask

  task automatic add_gap();
    repeat ($urandom_range(0, 16)) begin
      case ($urandom_range(0, 4))
        0: add_byte(CH_SPACE);
        1: add_byte(CH_TAB);
        2: add_byte(CH_CR);
        3: add_byte(CH_LF);
        default: add_byte(CH_BAR);
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report(input string msg);
    if (errors < LOG_CAP) $display("[%0d] MISMATCH %s", cycles, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report($sformatf("event %0d %s: got %0d, want %0d", events_seen, name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps
  // --------------------------------------------------------------------------

  int burst_left;
  int gap_left;

  always @(posedge clk) begin : sender
    logic       fired;
    logic [8:0] head;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.text_byte <= 8'd0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      fired = in_ch.valid && in_ch.ready;
      if (fired) begin
        predict_events(in_ch.text_byte);
        bytes_sent++;
      end
      // hold the current byte until it transfers, then pick the next one
      if (!in_ch.valid || fired) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (text_q.size() == 0 ||
                     (text_q[0][8] && pending_events.size() != 0)) begin
          // nothing left, or wait for the parser to drain before this byte
          in_ch.valid <= 1'b0;
        end else begin
          head = text_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.text_byte <= head[7:0];
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: check each transfer, stall in changing modes
  // --------------------------------------------------------------------------

  int stall_mode;
  int mode_left;
  int tick;

  always @(posedge clk) begin : receiver
    res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_mode = 0;
      mode_left  = 0;
      tick       = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_events.size() == 0) begin
          report($sformatf("event %0d arrived with nothing expected (kind %0d)",
                           events_seen, out_ch.event_kind));
        end else begin
          want = pending_events.pop_front();
          check_field("event_kind",     8'(out_ch.event_kind),     8'(want.kind));
          check_field("note_value",     8'(out_ch.note_value),     8'(want.note));
          check_field("chord_number",   8'(out_ch.chord_number),   8'(want.chord));
          check_field("notes_in_chord", 8'(out_ch.notes_in_chord), 8'(want.cnt));
          check_field("lowest_note",    8'(out_ch.lowest_note),    8'(want.low));
          check_field("big_chord",      8'(out_ch.big_chord),      8'(want.big));
          check_field("error_code",     8'(out_ch.error_code),     8'(want.err));
          check_field("last_of_run",    8'(out_ch.last_of_run),    8'(want.last));
          case (want.kind)
            KIND_NOTE:  notes_seen++;
            KIND_CLOSE: closes_seen++;
            KIND_END:   ends_seen++;
            default: begin
              faults_seen++;
              last_fault = int'(want.err);
            end
          endcase
        end
        events_seen++;
      end
      // always ready, coin flip, or ready only when tick is a multiple of four
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(5, 60);
      end else begin
        mode_left--;
      end
      tick++;
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= (tick % 4 == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles, %0d events still owed", cycles,
               pending_events.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------

  initial begin : main
    int         good;
    int         top;
    logic [7:0] b;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.text_byte = 8'd0;
    out_ch.ready    = 1'b0;
    cycles          = 0;
    errors          = 0;
    bytes_sent      = 0;
    events_seen     = 0;
    notes_seen      = 0;
    closes_seen     = 0;
    ends_seen       = 0;
    faults_seen     = 0;
    last_fault      = 0;
    hold_next       = 1'b0;

    cur_phase     = PH_START;
    pending_pitch = 6'd0;
    prior_pitch   = 6'd0;
    pitch_count   = 4'd0;
    tonic         = NO_TONIC;
    chords_done   = 7'd0;

    // Directed opening: empty chord, every blank, lowest and highest pitch,
    // and a chord filled to capacity whose last note is closed by ']'
    add_text("[]");
    add_byte(CH_SPACE);
    add_byte(CH_TAB);
    add_byte(CH_CR);
    add_byte(CH_LF);
    add_byte(CH_BAR);
    add_text("[C,^G,^b]");
    add_text("[CDEFGABc]");

    // Random chords up to the list limit; an in-chord ending uses the last slot
    finale = finale_t'($urandom_range(0, 5));
    good = (finale == END_TOO_MANY || finale == END_STRAY_BYTE) ? MAX_LIST - 3
                                                                : MAX_LIST - 4;
    hold_next = 1'b1;  // drain the directed part before the random text starts
    for (int i = 0; i < good; i++) begin
      add_byte(CH_LBR);
      add_notes($urandom_range(0, CHORD_CAP), top);
      add_byte(CH_RBR);
      if (i == good / 2) hold_next = 1'b1;
      add_gap();
    end

    case (finale)
      END_TOO_MANY: add_byte(CH_LBR);
      END_STRAY_BYTE: begin
        do b = 8'($urandom_range(0, 255)); while (is_gap_char(b) || b == CH_LBR);
        add_byte(b);
      end
      END_BAD_LETTER: begin
        add_byte(CH_LBR);
        add_notes($urandom_range(0, 4), top);
        do b = 8'($urandom_range(0, 255));
        while (pitch_of(b) != 0 || b == CH_CARET || b == CH_RBR || b == CH_COMMA);
        add_byte(b);
      end
      END_CARET_CLOSE: begin
        add_byte(CH_LBR);
        add_notes($urandom_range(0, 4), top);
        add_byte(CH_CARET);
        add_byte(CH_RBR);
      end
      END_DESCENT: begin
        add_byte(CH_LBR);
        add_notes($urandom_range(1, CHORD_CAP - 1), top);
        add_pitch($urandom_range(0, top));
        add_byte(CH_RBR);
      end
      default: begin
        add_byte(CH_LBR);
        add_notes(CHORD_CAP, top);
        do b = 8'($urandom_range(0, 255)); while (b == CH_RBR || b == CH_COMMA);
        add_byte(b);
      end
    endcase

    // Noise after the halt must be swallowed without any event
    add_byte(8'h00);
    add_byte(8'hFF);
    repeat (40) add_byte(8'($urandom_range(0, 255)));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // sample away from the active edge so queue updates have settled
    do @(negedge clk);
    while (text_q.size() != 0 || in_ch.valid || pending_events.size() != 0);
    repeat (SETTLE) @(negedge clk);

    if (pending_events.size() != 0)
      report($sformatf("%0d expected events never arrived", pending_events.size()));

    $display("Sent %0d text bytes and checked %0d events: %0d notes, %0d chord closes,",
             bytes_sent, events_seen, notes_seen, closes_seen);
    $display("  %0d list ends, %0d parse errors (code %0d); closing case %s",
             ends_seen, faults_seen, last_fault, finale.name());
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
